### src/dpmpp_pkg.sv
// Shared constants and types for the DPM-Solver++ 2M element update block.
`default_nettype none

package dpmpp_pkg;

   localparam int TENSOR_ELEMENTS = 16384;
   localparam int INDEX_WIDTH     = $clog2(TENSOR_ELEMENTS);
   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEFF_WIDTH     = 32;
   localparam int COEFF_FRAC      = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   // coefficient (unsigned, one sign bit added) times a 25-bit difference
   localparam int PRODUCT_WIDTH   = COEFF_WIDTH + 1 + SAMPLE_WIDTH + 1;
   localparam int SUM_WIDTH       = PRODUCT_WIDTH + 2;
   localparam int ROUNDED_WIDTH   = SUM_WIDTH - COEFF_FRAC;

   localparam logic [COEFF_WIDTH-1:0] RATIO_RESET = COEFF_WIDTH'(32'h0100_0000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SAMPLE_RATIO = 3'd0,
      CSR_PREDICTION   = 3'd1,
      CSR_DIFFERENCE   = 3'd2,
      CSR_FINAL_STEP   = 3'd3,
      CSR_FIRST_STEP   = 3'd4,
      CSR_USE_HISTORY  = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

### src/dpm_solver_pp_2m_update_top.sv
// DPM-Solver++ 2M element update: history memory, multiply pipeline, output register.
//
// Usage: before each pass over a latent tensor, write the step coefficients
// and mode flags through the csr_ channel (always ready, write only while the
// block is idle). Then stream the tensor on req_: each item carries one sample
// element and its x0-prediction, tlast marks the last element. One result item
// per input item leaves on rsp_ with the updated sample, a saturation flag in
// tuser and the end-of-pass mark in tlast.
// Throughput: one item per cycle while rsp_ does not stall. Each item does one
// read and, off the final step, one write of the history memory at its element
// index, both in its accept cycle; the read sees the previous pass, so no forwarding is needed.
// Pipeline: four register stages (memory read, difference, products,
// round/saturate); the result leaves on rsp_ from the last of them.
// Stall: when rsp_tready is low with a result waiting, the whole pipeline
// holds and req_tready drops in the same cycle; nothing is lost or repeated.
// Reset: control registers and coefficients return to their defaults, the
// element index to zero and the history to invalid. The history memory is not
// cleared; no clearing pass runs and the block is ready right after reset.
`default_nettype none

module dpm_solver_pp_2m_update_top
   import dpmpp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // stream in
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [2*SAMPLE_WIDTH-1:0]  req_tdata,  // [23:0] sample_value, [47:24] prediction_value
   input  wire logic                       req_tlast,  // last_element
   // stream out
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [SAMPLE_WIDTH-1:0]         rsp_tdata,  // [23:0] next_sample
   output logic                            rsp_tuser,  // [0] saturated
   output logic                            rsp_tlast,  // end_of_pass
   // register writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COEFF_WIDTH-1:0]     csr_data
);

   localparam logic signed [ROUNDED_WIDTH-1:0] SAT_MAX =
      ROUNDED_WIDTH'((1 <<< (SAMPLE_WIDTH-1)) - 1);
   localparam logic signed [ROUNDED_WIDTH-1:0] SAT_MIN =
      -ROUNDED_WIDTH'(1 <<< (SAMPLE_WIDTH-1));
   localparam logic [INDEX_WIDTH-1:0] INDEX_LAST = INDEX_WIDTH'(TENSOR_ELEMENTS - 1);

   // configuration
   logic [COEFF_WIDTH-1:0] ratio_ff, pred_coeff_ff, diff_coeff_ff;
   logic                   final_ff, first_ff, use_hist_ff;

   // pass state
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic                   hist_valid_ff;

   // history memory
   logic [SAMPLE_WIDTH-1:0] hist_mem [TENSOR_ELEMENTS];
   logic [SAMPLE_WIDTH-1:0] hist_rd_ff;

   // pipeline
   logic                           advance, req_accept;
   logic                           v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff, s1_pred_ff;
   logic                           s1_last_ff, s1_final_ff, s1_second_ff;
   logic signed [SAMPLE_WIDTH-1:0] s2_sample_ff, s2_pred_ff;
   logic signed [SAMPLE_WIDTH:0]   s2_diff_ff, diff_in;
   logic                           s2_last_ff, s2_final_ff;
   logic signed [PRODUCT_WIDTH-1:0] s3_ratio_prod_ff, s3_pred_prod_ff, s3_diff_prod_ff;
   logic signed [PRODUCT_WIDTH-1:0] ratio_prod_in, pred_prod_in, diff_prod_in;
   logic signed [SAMPLE_WIDTH-1:0] s3_pred_ff;
   logic                           s3_last_ff, s3_final_ff;
   logic signed [SUM_WIDTH-1:0]    sum_in;
   logic signed [ROUNDED_WIDTH-1:0] rounded_in;
   logic [SAMPLE_WIDTH-1:0]        result_in, out_data_ff;
   logic                           sat_in, out_sat_ff, out_last_ff;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff      <= RATIO_RESET;
         pred_coeff_ff <= '0;
         diff_coeff_ff <= '0;
         final_ff      <= 1'b0;
         first_ff      <= 1'b1;
         use_hist_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_RATIO: ratio_ff      <= csr_data;
            CSR_PREDICTION:   pred_coeff_ff <= csr_data;
            CSR_DIFFERENCE:   diff_coeff_ff <= csr_data;
            CSR_FINAL_STEP:   final_ff      <= csr_data[0];
            CSR_FIRST_STEP:   first_ff      <= csr_data[0];
            CSR_USE_HISTORY:  use_hist_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // element index and history state
   always_comb begin
      if (req_tlast || index_ff == INDEX_LAST) begin
         index_in = '0;
      end else begin
         index_in = index_ff + INDEX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         hist_valid_ff <= 1'b0;
      end else if (req_accept) begin
         index_ff <= index_in;
         if (!final_ff && req_tlast) begin
            hist_valid_ff <= 1'b1;
         end
      end
   end

   // read-first: the read returns the entry from the previous pass
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hist_rd_ff <= hist_mem[index_ff];
         if (!final_ff) begin
            hist_mem[index_ff] <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         end
      end
   end

   // stage 1: capture item, decide order
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         s1_pred_ff   <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         s1_last_ff   <= req_tlast;
         s1_final_ff  <= final_ff;
         s1_second_ff <= !first_ff && use_hist_ff && hist_valid_ff;
      end
   end

   // stage 2: prediction difference, zero in first order
   always_comb begin
      if (s1_second_ff) begin
         diff_in = (SAMPLE_WIDTH+1)'(s1_pred_ff) - (SAMPLE_WIDTH+1)'($signed(hist_rd_ff));
      end else begin
         diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sample_ff <= s1_sample_ff;
         s2_pred_ff   <= s1_pred_ff;
         s2_diff_ff   <= diff_in;
         s2_last_ff   <= s1_last_ff;
         s2_final_ff  <= s1_final_ff;
      end
   end

   // stage 3: three products
   assign ratio_prod_in = PRODUCT_WIDTH'($signed({1'b0, ratio_ff}) * s2_sample_ff);
   assign pred_prod_in  = PRODUCT_WIDTH'($signed({1'b0, pred_coeff_ff}) * s2_pred_ff);
   assign diff_prod_in  = PRODUCT_WIDTH'($signed({1'b0, diff_coeff_ff}) * s2_diff_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ratio_prod_ff <= ratio_prod_in;
         s3_pred_prod_ff  <= pred_prod_in;
         s3_diff_prod_ff  <= diff_prod_in;
         s3_pred_ff       <= s2_pred_ff;
         s3_last_ff       <= s2_last_ff;
         s3_final_ff      <= s2_final_ff;
      end
   end

   // stage 4: sum, round half up, saturate; on the final step pass the prediction through
   always_comb begin
      sum_in = SUM_WIDTH'(s3_ratio_prod_ff) + SUM_WIDTH'(s3_pred_prod_ff)
             + SUM_WIDTH'(s3_diff_prod_ff) + SUM_WIDTH'(1 <<< (COEFF_FRAC-1));
      rounded_in = ROUNDED_WIDTH'(sum_in >>> COEFF_FRAC);
      sat_in     = 1'b0;
      if (s3_final_ff) begin
         result_in = s3_pred_ff;
      end else if (rounded_in > SAT_MAX) begin
         result_in = SAT_MAX[SAMPLE_WIDTH-1:0];
         sat_in    = 1'b1;
      end else if (rounded_in < SAT_MIN) begin
         result_in = SAT_MIN[SAMPLE_WIDTH-1:0];
         sat_in    = 1'b1;
      end else begin
         result_in = rounded_in[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result_in;
         out_sat_ff  <= sat_in;
         out_last_ff <= s3_last_ff;
      end
   end

   // stage valids; the whole pipe holds while a result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
